@@ design/mvt_pkg.sv @@
// Shared types and constants for the 4x4 matrix vector transform block.
// Holds the item, result and command structs and the queue depths.
// No dependencies.
package mvt_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int MAT_DIM = 4;
	localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	typedef enum logic [1:0] {
		KIND_ELEMENT   = 2'd0,
		KIND_ROW       = 2'd1,
		KIND_COLUMN    = 2'd2,
		KIND_TRANSFORM = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [1:0]         row_index;
		logic [1:0]         column_index;
		logic signed [31:0] element_value;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] vec_w;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic               saturated;
	} result_t;

	typedef struct packed {
		kind_t                      kind;
		logic [MAT_ENTRIES-1:0]     write_mask;
		logic [31:0]                element_value;
		logic [MAT_DIM-1:0][31:0]   vec;
	} cmd_t;

endpackage

@@ design/mvt_front.sv @@
// Front end: accepts items, decodes them into commands with a matrix write mask,
// and holds them in a short command queue for the back end.
// Depends on mvt_pkg.
module mvt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mvt_pkg::item_t item,
	output logic          cmd_valid,
	output mvt_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import mvt_pkg::*;

	localparam int PTR_W = $clog2(CMD_DEPTH);

	cmd_t             queue_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	cmd_t             decoded;
	logic             push_ok;
	logic             pop_ok;

	always_comb begin
		decoded.kind = item.kind;
		decoded.element_value = item.element_value;
		decoded.vec[0] = item.vec_x;
		decoded.vec[1] = item.vec_y;
		decoded.vec[2] = item.vec_z;
		decoded.vec[3] = item.vec_w;
		for (int r = 0; r < MAT_DIM; r++) begin
			for (int c = 0; c < MAT_DIM; c++) begin
				case (item.kind)
					KIND_ELEMENT: begin
						decoded.write_mask[r*MAT_DIM+c] = (2'(r) == item.row_index) &&
							(2'(c) == item.column_index);
					end
					KIND_ROW: begin
						decoded.write_mask[r*MAT_DIM+c] = (2'(r) == item.row_index);
					end
					KIND_COLUMN: begin
						decoded.write_mask[r*MAT_DIM+c] = (2'(c) == item.column_index);
					end
					default: begin
						decoded.write_mask[r*MAT_DIM+c] = 1'b0;
					end
				endcase
			end
		end
	end

	assign full      = (count_q == (PTR_W+1)'(CMD_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/mvt_back.sv @@
// Back end: owns the matrix registers, applies writes in order and runs the
// multiply, add, add and shift/saturate pipeline for transforms.
// Depends on mvt_pkg.
module mvt_back #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  mvt_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	input  logic             res_taken,
	output logic             res_valid,
	output mvt_pkg::result_t res
);
	import mvt_pkg::*;

	localparam int USED_W = $clog2(OUT_DEPTH) + 1;
	localparam logic [31:0] UNIT = 32'(1) << FRAC_BITS;

	logic [31:0]        matrix_q  [MAT_DIM][MAT_DIM];
	logic [31:0]        write_data [MAT_DIM][MAT_DIM];
	logic [USED_W-1:0]  used_q;
	logic               issue;
	logic               xform_issue;

	logic signed [63:0] prod_s1 [MAT_DIM][MAT_DIM];
	logic signed [64:0] pair_s2 [MAT_DIM][2];
	logic signed [65:0] sum_s3  [MAT_DIM];
	logic signed [65:0] shifted [MAT_DIM];
	logic [31:0]        clipped [MAT_DIM];
	logic [MAT_DIM-1:0] clip_flag;
	result_t            res_s4;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;

	assign issue       = cmd_valid && (used_q != USED_W'(OUT_DEPTH));
	assign xform_issue = issue && (cmd.kind == KIND_TRANSFORM);
	assign cmd_pop     = issue;

	always_comb begin
		for (int r = 0; r < MAT_DIM; r++) begin
			for (int c = 0; c < MAT_DIM; c++) begin
				case (cmd.kind)
					KIND_ROW:    write_data[r][c] = cmd.vec[c];
					KIND_COLUMN: write_data[r][c] = cmd.vec[r];
					default:     write_data[r][c] = cmd.element_value;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					matrix_q[r][c] <= (r == MAT_DIM-1 && c == MAT_DIM-1) ? UNIT : '0;
				end
			end
		end else if (issue) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					if (cmd.write_mask[r*MAT_DIM+c]) begin
						matrix_q[r][c] <= write_data[r][c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xform_issue) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				for (int c = 0; c < MAT_DIM; c++) begin
					prod_s1[r][c] <= $signed(matrix_q[r][c]) * $signed(cmd.vec[c]);
				end
			end
		end
		if (valid_s1) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				pair_s2[r][0] <= {prod_s1[r][0][63], prod_s1[r][0]} +
					{prod_s1[r][1][63], prod_s1[r][1]};
				pair_s2[r][1] <= {prod_s1[r][2][63], prod_s1[r][2]} +
					{prod_s1[r][3][63], prod_s1[r][3]};
			end
		end
		if (valid_s2) begin
			for (int r = 0; r < MAT_DIM; r++) begin
				sum_s3[r] <= {pair_s2[r][0][64], pair_s2[r][0]} +
					{pair_s2[r][1][64], pair_s2[r][1]};
			end
		end
		if (valid_s3) begin
			res_s4.out_x     <= clipped[0];
			res_s4.out_y     <= clipped[1];
			res_s4.out_z     <= clipped[2];
			res_s4.out_w     <= clipped[3];
			res_s4.saturated <= |clip_flag;
		end
	end

	always_comb begin
		for (int r = 0; r < MAT_DIM; r++) begin
			shifted[r] = sum_s3[r] >>> FRAC_BITS;
			if ((&shifted[r][65:31]) || !(|shifted[r][65:31])) begin
				clipped[r]   = shifted[r][31:0];
				clip_flag[r] = 1'b0;
			end else begin
				clipped[r]   = shifted[r][65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				clip_flag[r] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			used_q   <= '0;
		end else begin
			valid_s1 <= xform_issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			case ({xform_issue, res_taken})
				2'b10:   used_q <= used_q + 1'b1;
				2'b01:   used_q <= used_q - 1'b1;
				default: used_q <= used_q;
			endcase
		end
	end

	assign res_valid = valid_s4;
	assign res       = res_s4;

endmodule

@@ design/mvt_out_fifo.sv @@
// Result queue between the back end pipeline and the result port.
// Space is reserved by the back end before a transform enters the pipeline.
// Depends on mvt_pkg.
module mvt_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  mvt_pkg::result_t wr_data,
	output logic             empty,
	input  logic             pop,
	output mvt_pkg::result_t rd_data
);
	import mvt_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);

	result_t          entry_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop_ok;

	assign empty   = (count_q == '0);
	assign pop_ok  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_valid, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/matrix4_vector_transform_core.sv @@
// 4x4 signed fixed-point matrix times vector transform, one item per cycle unless stalled.
// Items enter through a push/full queue port: kinds element, row and column
// write the stored matrix and produce nothing; kind transform produces one
// result, each component a row dot product shifted by FRAC_BITS and saturated.
// Results leave through an empty/pop queue port, oldest first.
// A transform waits in the command queue, then passes through multiply, two add
// stages and shift/saturate, then the result queue. A write affects every
// transform accepted after it. Sustained rate is one item per clock while the
// result queue has unreserved space, set by the sixteen parallel multipliers
// that all see the matrix registers.
// Reset loads the identity's bottom-right one and zeros elsewhere and empties
// both queues. When pop stays low, finished results collect in an eight-entry
// result queue; items wait in the command queue once that space is
// reserved, and full rises when the four-entry command queue fills.
// Depends on mvt_pkg, mvt_front, mvt_back and mvt_out_fifo.
module matrix4_vector_transform_core #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  mvt_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output mvt_pkg::result_t result
);
	import mvt_pkg::*;

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	logic    res_valid;
	result_t res;
	logic    res_taken;

	assign res_taken = pop && !empty;

	mvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mvt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_taken (res_taken),
		.res_valid (res_valid),
		.res       (res)
	);

	mvt_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (res_valid),
		.wr_data  (res),
		.empty    (empty),
		.pop      (pop),
		.rd_data  (result)
	);

endmodule
